@@ rtl/core/tsh_pkg.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// tsh_pkg
// Shared widths, codes and constants of the thermistor Steinhart-Hart block.
// ---------------------------------------------------------------------------
package tsh_pkg;

    localparam int CH_W    = 4;
    localparam int SR_W    = 20;
    localparam int COEF_W  = 32;
    localparam int TEMP_W  = 18;
    localparam int ST_W    = 2;
    localparam int IDX_W   = 2;
    localparam int DATA_W  = 32;
    localparam int Q_DEPTH = 4;

    // resistance carries 16 fraction bits
    localparam int FX_W    = 16;
    // log unit
    localparam int NORM_W  = 64;
    localparam int POS_W   = 6;
    localparam int MANT_W  = 32;
    localparam int FRAC_W  = 28;
    localparam int LN2_W   = 30;
    localparam logic [LN2_W-1:0] LN2_Q30 = 30'd744261118;
    localparam int LN_W    = 32;
    localparam int LN_SH   = LN2_W + FRAC_W - 24;
    // polynomial
    localparam int L2_SH   = 24;
    localparam int L2_W    = 36;
    localparam int L3_SH   = 32;
    localparam int L3_W    = 34;
    localparam int BP_W    = COEF_W + 1 + LN_W;
    localparam int CP_W    = COEF_W + 1 + L3_W;
    localparam int B_SH    = 24;
    localparam int C_SH    = 16;
    localparam int DS_W    = 53;
    localparam int D_W     = 49;
    // kelvin = 2^56 / D, clamped to 2^32
    localparam int T_NUM_SH = 56;
    localparam int T_QW     = 32;
    localparam int D_LIM_SH = T_NUM_SH - T_QW;
    // Fahrenheit scaling
    localparam int F_W     = 43;
    localparam logic [F_W-1:0] F_MUL = 43'd180;
    localparam logic [F_W-1:0] F_OFF = 43'd3012493312;
    localparam logic [TEMP_W-1:0] TEMP_MAX = 18'h1FFFF;
    localparam logic [TEMP_W-1:0] TEMP_MIN = 18'h20000;

    localparam logic [IDX_W-1:0] REG_SERIES = 2'd0;
    localparam logic [IDX_W-1:0] REG_COEF_A = 2'd1;
    localparam logic [IDX_W-1:0] REG_COEF_B = 2'd2;
    localparam logic [IDX_W-1:0] REG_COEF_C = 2'd3;

    localparam logic [SR_W-1:0]   RST_SERIES = 20'd10000;
    localparam logic [COEF_W-1:0] RST_COEF_A = 32'd1109681585;
    localparam logic [COEF_W-1:0] RST_COEF_B = 32'd261508444;
    localparam logic [COEF_W-1:0] RST_COEF_C = 32'd222014;

    typedef enum logic [ST_W-1:0] {
        ST_OK    = 2'd0,
        ST_OPEN  = 2'd1,
        ST_SHORT = 2'd2
    } t_status;

    typedef struct packed {
        logic [CH_W-1:0] channel;
        t_status         status;
    } t_tag;

endpackage
`default_nettype wire

@@ rtl/core/tsh_front.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// tsh_front
// Input register: classifies the code and forms the divider numerator.
// ---------------------------------------------------------------------------
module tsh_front #(
    parameter int ADC_BITS = 10
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_valid,
    output logic                                  o_ready,
    input  logic [tsh_pkg::CH_W-1:0]              i_channel,
    input  logic [ADC_BITS-1:0]                   i_adc_code,
    input  logic [tsh_pkg::SR_W-1:0]              i_series,
    input  logic                                  i_space,
    output logic                                  o_push,
    output tsh_pkg::t_tag                         o_tag,
    output logic [ADC_BITS-1:0]                   o_code,
    output logic [tsh_pkg::SR_W+ADC_BITS-1:0]     o_num
);
    import tsh_pkg::*;

    localparam logic [ADC_BITS-1:0] FULL = '1;

    logic                r_valid;
    logic                n_valid;
    logic [CH_W-1:0]     r_ch;
    logic [ADC_BITS-1:0] r_code;
    t_status             status;

    assign o_ready = !r_valid || i_space;
    assign o_push  = r_valid && i_space;

    always_comb begin
        n_valid = r_valid;
        if (i_valid && o_ready) begin
            n_valid = 1'b1;
        end else if (o_push) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_ch   <= i_channel;
            r_code <= i_adc_code;
        end
    end

    always_comb begin
        if (r_code == '0) begin
            status = ST_OPEN;
        end else if (r_code == FULL) begin
            status = ST_SHORT;
        end else begin
            status = ST_OK;
        end
    end

    assign o_tag  = '{channel: r_ch, status: status};
    assign o_code = r_code;
    assign o_num  = i_series * (FULL - r_code);

endmodule
`default_nettype wire

@@ rtl/core/tsh_queue.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// tsh_queue
// Small FIFO between the front register and the conversion pipeline.
// ---------------------------------------------------------------------------
module tsh_queue #(
    parameter int W = 8
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  logic [W-1:0] i_data,
    output logic         o_space,
    input  logic         i_pop,
    output logic         o_valid,
    output logic [W-1:0] o_data
);
    import tsh_pkg::*;

    localparam int PTR_W = $clog2(Q_DEPTH);

    logic [W-1:0]     r_mem [Q_DEPTH];
    logic [PTR_W-1:0] r_wr;
    logic [PTR_W-1:0] r_rd;
    logic [PTR_W:0]   r_cnt;
    logic             do_pop;

    assign o_space = r_cnt != (PTR_W+1)'(Q_DEPTH);
    assign o_valid = r_cnt != '0;
    assign o_data  = r_mem[r_rd];
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            if (i_push && !do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_pop && !i_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule
`default_nettype wire

@@ rtl/core/tsh_div.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// tsh_div
// Pipelined restoring divider, one quotient bit per stage. The caller
// supplies a starting remainder below the divisor and the low dividend bits.
// ---------------------------------------------------------------------------
module tsh_div #(
    parameter int DW = 10,
    parameter int QW = 46,
    parameter int TW = 6
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic          i_valid,
    input  logic [DW-1:0] i_rem,
    input  logic [QW-1:0] i_dq,
    input  logic [DW-1:0] i_div,
    input  logic [TW-1:0] i_tag,
    output logic          o_valid,
    output logic [QW-1:0] o_quo,
    output logic [TW-1:0] o_tag
);
    logic          r_v   [QW];
    logic [DW-1:0] r_rem [QW];
    logic [QW-1:0] r_dq  [QW];
    logic [DW-1:0] r_dv  [QW];
    logic [TW-1:0] r_tg  [QW];

    logic          a_v   [QW];
    logic [DW-1:0] a_rem [QW];
    logic [QW-1:0] a_dq  [QW];
    logic [DW-1:0] a_dv  [QW];
    logic [TW-1:0] a_tg  [QW];

    logic [DW-1:0] n_rem [QW];
    logic [QW-1:0] n_dq  [QW];

    always_comb begin
        a_v[0]   = i_valid;
        a_rem[0] = i_rem;
        a_dq[0]  = i_dq;
        a_dv[0]  = i_div;
        a_tg[0]  = i_tag;
        for (int s = 1; s < QW; s++) begin
            a_v[s]   = r_v[s-1];
            a_rem[s] = r_rem[s-1];
            a_dq[s]  = r_dq[s-1];
            a_dv[s]  = r_dv[s-1];
            a_tg[s]  = r_tg[s-1];
        end
    end

    always_comb begin
        logic [DW:0] rem2;
        logic [DW:0] diff;
        logic        ge;
        for (int s = 0; s < QW; s++) begin
            rem2     = {a_rem[s], a_dq[s][QW-1]};
            diff     = rem2 - {1'b0, a_dv[s]};
            ge       = rem2 >= {1'b0, a_dv[s]};
            n_rem[s] = ge ? diff[DW-1:0] : rem2[DW-1:0];
            n_dq[s]  = {a_dq[s][QW-2:0], ge};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < QW; s++) begin
                r_v[s] <= 1'b0;
            end
        end else if (i_en) begin
            for (int s = 0; s < QW; s++) begin
                r_v[s] <= a_v[s];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int s = 0; s < QW; s++) begin
                r_rem[s] <= n_rem[s];
                r_dq[s]  <= n_dq[s];
                r_dv[s]  <= a_dv[s];
                r_tg[s]  <= a_tg[s];
            end
        end
    end

    assign o_valid = r_v[QW-1];
    assign o_quo   = r_dq[QW-1];
    assign o_tag   = r_tg[QW-1];

endmodule
`default_nettype wire

@@ rtl/core/tsh_log.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// tsh_log
// Pipelined natural log of a Q16 resistance: leading-one normalize in
// binary steps, one squaring per fraction bit, then scale by ln 2.
// ---------------------------------------------------------------------------
module tsh_log #(
    parameter int TW = 6
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_en,
    input  logic                              i_valid,
    input  logic [tsh_pkg::NORM_W-1:0]        i_x,
    input  logic [TW-1:0]                     i_tag,
    output logic                              o_valid,
    output logic signed [tsh_pkg::LN_W-1:0]   o_ln,
    output logic [TW-1:0]                     o_tag
);
    import tsh_pkg::*;

    localparam int NS     = POS_W;
    localparam int FS     = FRAC_W;
    localparam int PF_W   = FRAC_W + LN2_W;
    localparam int PI_W   = POS_W + 1 + LN2_W + 1;
    localparam int LS_W   = PI_W + FRAC_W + 1;
    localparam int IP_OFF = NORM_W - 1 - FX_W;

    // normalize stages
    logic              r_nv  [NS];
    logic [NORM_W-1:0] r_nx  [NS];
    logic [POS_W-1:0]  r_nlz [NS];
    logic [TW-1:0]     r_ntg [NS];
    logic [NORM_W-1:0] n_nx  [NS];
    logic [POS_W-1:0]  n_nlz [NS];

    // squaring stages
    logic              r_sv  [FS];
    logic [MANT_W-1:0] r_sm  [FS];
    logic [FRAC_W-1:0] r_sf  [FS];
    logic [POS_W-1:0]  r_slz [FS];
    logic [TW-1:0]     r_stg [FS];
    logic [MANT_W-1:0] n_sm  [FS];
    logic [FRAC_W-1:0] n_sf  [FS];

    // scale stages
    logic                    r_l1_v;
    logic [PF_W-1:0]         r_l1_pf;
    logic signed [PI_W-1:0]  r_l1_pi;
    logic [TW-1:0]           r_l1_tg;
    logic                    r_l2_v;
    logic signed [LN_W-1:0]  r_l2_ln;
    logic [TW-1:0]           r_l2_tg;

    logic signed [POS_W:0]   ipart;
    logic signed [LN2_W:0]   ln2_s;
    logic signed [PI_W-1:0]  n_pi;
    logic [PF_W-1:0]         n_pf;
    logic signed [LS_W-1:0]  pi_ext;
    logic signed [LS_W-1:0]  pf_ext;
    logic signed [LS_W-1:0]  lsum;

    always_comb begin
        logic [NORM_W-1:0] x_in;
        logic [POS_W-1:0]  lz_in;
        int                sh;
        for (int g = 0; g < NS; g++) begin
            if (g == 0) begin
                x_in  = i_x;
                lz_in = '0;
            end else begin
                x_in  = r_nx[g-1];
                lz_in = r_nlz[g-1];
            end
            sh = 1 << (NS - 1 - g);
            if ((x_in >> (NORM_W - sh)) == '0) begin
                n_nx[g]  = x_in << sh;
                n_nlz[g] = lz_in + POS_W'(sh);
            end else begin
                n_nx[g]  = x_in;
                n_nlz[g] = lz_in;
            end
        end
    end

    always_comb begin
        logic [MANT_W-1:0]   m_in;
        logic [FRAC_W-1:0]   f_in;
        logic [2*MANT_W-1:0] sq;
        logic [MANT_W:0]     t;
        for (int s = 0; s < FS; s++) begin
            if (s == 0) begin
                m_in = r_nx[NS-1][NORM_W-1 -: MANT_W];
                f_in = '0;
            end else begin
                m_in = r_sm[s-1];
                f_in = r_sf[s-1];
            end
            sq = m_in * m_in;
            t  = sq[2*MANT_W-1:MANT_W-1];
            if (t[MANT_W]) begin
                n_sm[s] = t[MANT_W:1];
                n_sf[s] = {f_in[FRAC_W-2:0], 1'b1};
            end else begin
                n_sm[s] = t[MANT_W-1:0];
                n_sf[s] = {f_in[FRAC_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int g = 0; g < NS; g++) begin
                r_nv[g] <= 1'b0;
            end
            for (int s = 0; s < FS; s++) begin
                r_sv[s] <= 1'b0;
            end
            r_l1_v <= 1'b0;
            r_l2_v <= 1'b0;
        end else if (i_en) begin
            r_nv[0] <= i_valid;
            for (int g = 1; g < NS; g++) begin
                r_nv[g] <= r_nv[g-1];
            end
            r_sv[0] <= r_nv[NS-1];
            for (int s = 1; s < FS; s++) begin
                r_sv[s] <= r_sv[s-1];
            end
            r_l1_v <= r_sv[FS-1];
            r_l2_v <= r_l1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ntg[0] <= i_tag;
            for (int g = 0; g < NS; g++) begin
                r_nx[g]  <= n_nx[g];
                r_nlz[g] <= n_nlz[g];
            end
            for (int g = 1; g < NS; g++) begin
                r_ntg[g] <= r_ntg[g-1];
            end
            r_slz[0] <= r_nlz[NS-1];
            r_stg[0] <= r_ntg[NS-1];
            for (int s = 0; s < FS; s++) begin
                r_sm[s] <= n_sm[s];
                r_sf[s] <= n_sf[s];
            end
            for (int s = 1; s < FS; s++) begin
                r_slz[s] <= r_slz[s-1];
                r_stg[s] <= r_stg[s-1];
            end
            r_l1_pf <= n_pf;
            r_l1_pi <= n_pi;
            r_l1_tg <= r_stg[FS-1];
            r_l2_ln <= lsum[LN_SH+LN_W-1:LN_SH];
            r_l2_tg <= r_l1_tg;
        end
    end

    // integer part of log2, less the 16 fraction bits of the input
    assign ipart  = $signed((POS_W+1)'(IP_OFF)) - $signed({1'b0, r_slz[FS-1]});
    assign ln2_s  = $signed({1'b0, LN2_Q30});
    assign n_pi   = ipart * ln2_s;
    assign n_pf   = r_sf[FS-1] * LN2_Q30;
    assign pi_ext = r_l1_pi;
    assign pf_ext = $signed({{(LS_W-PF_W){1'b0}}, r_l1_pf});
    assign lsum   = (pi_ext <<< FRAC_W) + pf_ext;

    assign o_valid = r_l2_v;
    assign o_ln    = r_l2_ln;
    assign o_tag   = r_l2_tg;

endmodule
`default_nettype wire

@@ rtl/core/tsh_back.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// tsh_back
// Conversion pipeline: resistance divide, log, Steinhart-Hart polynomial,
// kelvin divide, Fahrenheit scaling and the output register.
// ---------------------------------------------------------------------------
module tsh_back #(
    parameter int ADC_BITS = 10
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_pop,
    input  tsh_pkg::t_tag                       i_tag,
    input  logic [ADC_BITS-1:0]                 i_code,
    input  logic [tsh_pkg::SR_W+ADC_BITS-1:0]   i_num,
    input  logic [tsh_pkg::COEF_W-1:0]          i_coef_a,
    input  logic [tsh_pkg::COEF_W-1:0]          i_coef_b,
    input  logic [tsh_pkg::COEF_W-1:0]          i_coef_c,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic [tsh_pkg::CH_W-1:0]            o_channel_out,
    output logic signed [tsh_pkg::TEMP_W-1:0]   o_temp_centi_f,
    output tsh_pkg::t_status                    o_status
);
    import tsh_pkg::*;

    localparam int NUM_W = SR_W + ADC_BITS;
    localparam int RQ_W  = NUM_W + FX_W;
    localparam int TAG_W = $bits(t_tag);
    localparam int Q_W   = F_W - FX_W;
    localparam logic signed [DS_W-1:0] D_LIM = DS_W'(64'd1 << D_LIM_SH);

    logic adv;
    logic r_ov;

    // resistance divide
    logic              rq_v;
    logic [RQ_W-1:0]   rq_q;
    logic [TAG_W-1:0]  rq_tg;
    logic [NORM_W-1:0] rq_x;

    // log
    logic                   ln_v;
    logic signed [LN_W-1:0] ln;
    logic [TAG_W-1:0]       ln_tg;

    // polynomial stages
    logic                       r_p1_v, r_p2_v, r_p3_v, r_p4_v;
    t_tag                       r_p1_tg, r_p2_tg, r_p3_tg, r_p4_tg;
    logic signed [LN_W-1:0]     r_p1_l;
    logic signed [L2_W-1:0]     r_p1_l2;
    logic signed [BP_W-1:0]     r_p1_bp, r_p2_bp, r_p3_bp;
    logic signed [L3_W-1:0]     r_p2_l3;
    logic signed [CP_W-1:0]     r_p3_cp;
    logic [D_W-1:0]             r_p4_d;
    logic                       r_p4_sat;

    logic signed [2*LN_W-1:0]      sq_ll;
    logic signed [COEF_W:0]        b_s;
    logic signed [COEF_W:0]        c_s;
    logic signed [BP_W-1:0]        n_bp;
    logic signed [L2_W+LN_W-1:0]   m23;
    logic signed [CP_W-1:0]        n_cp;
    logic signed [BP_W-B_SH-1:0]   b_sh;
    logic signed [CP_W-C_SH-1:0]   c_sh;
    logic signed [DS_W-1:0]        dsum;

    // kelvin divide
    logic             t_v;
    logic [T_QW-1:0]  t_q;
    logic [TAG_W:0]   t_tg;
    logic [T_QW:0]    tval;

    // Fahrenheit and output
    logic             r_f1_v;
    t_tag             r_f1_tg;
    logic [F_W-1:0]   r_f1_num;
    logic             neg;
    logic [F_W-1:0]   mag;
    logic [Q_W-1:0]   q;
    logic [TEMP_W-1:0] temp;
    logic [CH_W-1:0]  r_och;
    logic [TEMP_W-1:0] r_otemp;
    t_status          r_ost;

    // the whole pipeline moves together; it holds while the output waits
    assign adv   = !r_ov || i_ready;
    assign o_pop = adv;

    tsh_div #(
        .DW (ADC_BITS),
        .QW (RQ_W),
        .TW (TAG_W)
    ) u_div_r (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (adv),
        .i_valid (i_valid),
        .i_rem   ({ADC_BITS{1'b0}}),
        .i_dq    ({i_num, {FX_W{1'b0}}}),
        .i_div   (i_code),
        .i_tag   (i_tag),
        .o_valid (rq_v),
        .o_quo   (rq_q),
        .o_tag   (rq_tg)
    );

    // a zero series resistor gives the smallest nonzero resistance
    assign rq_x = (rq_q == '0) ? NORM_W'(1) : NORM_W'(rq_q);

    tsh_log #(
        .TW (TAG_W)
    ) u_log (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (adv),
        .i_valid (rq_v),
        .i_x     (rq_x),
        .i_tag   (rq_tg),
        .o_valid (ln_v),
        .o_ln    (ln),
        .o_tag   (ln_tg)
    );

    assign b_s   = $signed({1'b0, i_coef_b});
    assign c_s   = $signed({1'b0, i_coef_c});
    assign sq_ll = ln * ln;
    assign n_bp  = b_s * ln;
    assign m23   = r_p1_l2 * r_p1_l;
    assign n_cp  = c_s * r_p2_l3;
    assign b_sh  = r_p3_bp[BP_W-1:B_SH];
    assign c_sh  = r_p3_cp[CP_W-1:C_SH];
    assign dsum  = $signed({{(DS_W-COEF_W){1'b0}}, i_coef_a}) + b_sh + c_sh;

    assign tval = t_tg[TAG_W] ? {1'b1, {T_QW{1'b0}}} : {1'b0, t_q};

    always_comb begin
        neg = r_f1_num[F_W-1];
        mag = neg ? (~r_f1_num + 1'b1) : r_f1_num;
        q   = mag[F_W-1:FX_W];
        if (r_f1_tg.status != ST_OK) begin
            temp = '0;
        end else if (!neg) begin
            temp = (q > Q_W'(2**(TEMP_W-1) - 1)) ? TEMP_MAX : q[TEMP_W-1:0];
        end else begin
            temp = (q > Q_W'(2**(TEMP_W-1))) ? TEMP_MIN : (~q[TEMP_W-1:0] + 1'b1);
        end
    end

    tsh_div #(
        .DW (D_W),
        .QW (T_QW),
        .TW (TAG_W + 1)
    ) u_div_t (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (adv),
        .i_valid (r_p4_v),
        .i_rem   (D_W'(64'd1 << D_LIM_SH)),
        .i_dq    ({T_QW{1'b0}}),
        .i_div   (r_p4_d),
        .i_tag   ({r_p4_sat, r_p4_tg}),
        .o_valid (t_v),
        .o_quo   (t_q),
        .o_tag   (t_tg)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1_v <= 1'b0;
            r_p2_v <= 1'b0;
            r_p3_v <= 1'b0;
            r_p4_v <= 1'b0;
            r_f1_v <= 1'b0;
            r_ov   <= 1'b0;
        end else if (adv) begin
            r_p1_v <= ln_v;
            r_p2_v <= r_p1_v;
            r_p3_v <= r_p2_v;
            r_p4_v <= r_p3_v;
            r_f1_v <= t_v;
            r_ov   <= r_f1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_p1_tg  <= t_tag'(ln_tg);
            r_p1_l   <= ln;
            r_p1_l2  <= sq_ll[L2_SH+L2_W-1:L2_SH];
            r_p1_bp  <= n_bp;
            r_p2_tg  <= r_p1_tg;
            r_p2_l3  <= m23[L3_SH+L3_W-1:L3_SH];
            r_p2_bp  <= r_p1_bp;
            r_p3_tg  <= r_p2_tg;
            r_p3_cp  <= n_cp;
            r_p3_bp  <= r_p2_bp;
            r_p4_tg  <= r_p3_tg;
            r_p4_d   <= dsum[D_W-1:0];
            // a denominator this small puts kelvin at its ceiling
            r_p4_sat <= dsum <= D_LIM;
            r_f1_tg  <= t_tag'(t_tg[TAG_W-1:0]);
            r_f1_num <= F_W'(tval) * F_MUL - F_OFF;
            r_och    <= r_f1_tg.channel;
            r_otemp  <= temp;
            r_ost    <= r_f1_tg.status;
        end
    end

    assign o_valid        = r_ov;
    assign o_channel_out  = r_och;
    assign o_temp_centi_f = r_otemp;
    assign o_status       = r_ost;

endmodule
`default_nettype wire

@@ rtl/core/thermistor_steinhart_hart.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// thermistor_steinhart_hart
// Thermistor divider code to hundredths of a degree Fahrenheit through the
// Steinhart-Hart equation.
//
//   channel  direction  handshake               payload
//   in       input      i_valid / o_ready       i_channel, i_adc_code
//   out      output     o_valid / i_ready       o_channel_out, o_temp_centi_f,
//                                               o_status
//   cfg      input      i_cfg_we                i_cfg_idx, i_cfg_data
//
// One item per cycle sustained while the output is not stalled. The pipeline
// depth is set by the two bit-per-stage dividers and the 28 squaring stages
// of the log unit.
// Reset is synchronous and active low; it clears the control state and loads
// the register defaults. A stalled output holds the whole pipeline; the input
// side keeps taking items until the four-entry queue fills.
// ---------------------------------------------------------------------------
module thermistor_steinhart_hart #(
    parameter int ADC_BITS = 10
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic [tsh_pkg::CH_W-1:0]            i_channel,
    input  logic [ADC_BITS-1:0]                 i_adc_code,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic [tsh_pkg::CH_W-1:0]            o_channel_out,
    output logic signed [tsh_pkg::TEMP_W-1:0]   o_temp_centi_f,
    output logic [tsh_pkg::ST_W-1:0]            o_status,
    input  logic                                i_cfg_we,
    input  logic [tsh_pkg::IDX_W-1:0]           i_cfg_idx,
    input  logic [tsh_pkg::DATA_W-1:0]          i_cfg_data
);
    import tsh_pkg::*;

    localparam int NUM_W = SR_W + ADC_BITS;
    localparam int ENT_W = $bits(t_tag) + ADC_BITS + NUM_W;

    logic [SR_W-1:0]   r_series;
    logic [COEF_W-1:0] r_coef_a;
    logic [COEF_W-1:0] r_coef_b;
    logic [COEF_W-1:0] r_coef_c;

    logic                space;
    logic                push;
    t_tag                f_tag;
    logic [ADC_BITS-1:0] f_code;
    logic [NUM_W-1:0]    f_num;
    logic                q_valid;
    logic                q_pop;
    logic [ENT_W-1:0]    q_data;
    t_tag                b_tag;
    logic [ADC_BITS-1:0] b_code;
    logic [NUM_W-1:0]    b_num;
    t_status             status;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_series <= RST_SERIES;
            r_coef_a <= RST_COEF_A;
            r_coef_b <= RST_COEF_B;
            r_coef_c <= RST_COEF_C;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_SERIES: r_series <= i_cfg_data[SR_W-1:0];
                REG_COEF_A: r_coef_a <= i_cfg_data[COEF_W-1:0];
                REG_COEF_B: r_coef_b <= i_cfg_data[COEF_W-1:0];
                REG_COEF_C: r_coef_c <= i_cfg_data[COEF_W-1:0];
                default: ;
            endcase
        end
    end

    tsh_front #(
        .ADC_BITS (ADC_BITS)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_channel  (i_channel),
        .i_adc_code (i_adc_code),
        .i_series   (r_series),
        .i_space    (space),
        .o_push     (push),
        .o_tag      (f_tag),
        .o_code     (f_code),
        .o_num      (f_num)
    );

    tsh_queue #(
        .W (ENT_W)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  ({f_tag, f_code, f_num}),
        .o_space (space),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_data  (q_data)
    );

    assign {b_tag, b_code, b_num} = q_data;

    tsh_back #(
        .ADC_BITS (ADC_BITS)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (q_valid),
        .o_pop          (q_pop),
        .i_tag          (b_tag),
        .i_code         (b_code),
        .i_num          (b_num),
        .i_coef_a       (r_coef_a),
        .i_coef_b       (r_coef_b),
        .i_coef_c       (r_coef_c),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_channel_out  (o_channel_out),
        .o_temp_centi_f (o_temp_centi_f),
        .o_status       (status)
    );

    assign o_status = status;

endmodule
`default_nettype wire

@@ test/tb_thermistor_steinhart_hart.sv @@
// ---------------------------------------------------------------------------
// tb_thermistor_steinhart_hart
// Drives divider codes through the converter under several register settings
// and checks every transfer on the result side against a fixed-point
// prediction of resistance, log, Steinhart-Hart and Fahrenheit scaling.
// ---------------------------------------------------------------------------
module tb_thermistor_steinhart_hart;
    timeunit 1ns;
    timeprecision 1ps;
    import tsh_pkg::*;

    localparam int ADC_BITS  = 10;
    localparam longint FULL  = (64'd1 << ADC_BITS) - 1;
    localparam int WD_LIMIT  = 20000;

    typedef struct packed {
        logic [CH_W-1:0]     channel;
        logic [ADC_BITS-1:0] code;
    } t_sample;

    typedef struct packed {
        logic [CH_W-1:0]          channel;
        logic signed [TEMP_W-1:0] temp;
        t_status                  status;
    } t_reading;

    logic                       i_clk = 1'b0;
    logic                       i_rst_n = 1'b0;
    logic                       i_valid = 1'b0;
    logic                       o_ready;
    logic [CH_W-1:0]            i_channel = '0;
    logic [ADC_BITS-1:0]        i_adc_code = '0;
    logic                       o_valid;
    logic                       i_ready = 1'b0;
    logic [CH_W-1:0]            o_channel_out;
    logic signed [TEMP_W-1:0]   o_temp_centi_f;
    logic [ST_W-1:0]            o_status;
    logic                       i_cfg_we = 1'b0;
    logic [IDX_W-1:0]           i_cfg_idx = REG_SERIES;
    logic [DATA_W-1:0]          i_cfg_data = '0;

    thermistor_steinhart_hart #(.ADC_BITS(ADC_BITS)) dut (.*);

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // register mirror
    logic [SR_W-1:0]   series_ohms = RST_SERIES;
    logic [COEF_W-1:0] sh_a = RST_COEF_A;
    logic [COEF_W-1:0] sh_b = RST_COEF_B;
    logic [COEF_W-1:0] sh_c = RST_COEF_C;

    t_sample  pending_samples[$];
    t_reading expected_readings[$];
    int       error_count = 0;

    function automatic t_reading convert_sample(t_sample s);
        t_reading   r;
        logic [63:0] rq, x;
        int          p;
        longint      frac, lg2, ln_r, sq, cube, den, kel, num, tc;
        r.channel = s.channel;
        r.temp    = '0;
        r.status  = ST_OK;
        if (s.code == 0) begin
            r.status = ST_OPEN;
        end else if (s.code == FULL) begin
            r.status = ST_SHORT;
        end else begin
            rq = ((64'(series_ohms) * (FULL - 64'(s.code))) << 16) / 64'(s.code);
            if (rq == 0) rq = 1;
            p = 0;
            while (p < 63 && (rq >> (p + 1)) != 0) p++;
            x = (p >= 31) ? (rq >> (p - 31)) : (rq << (31 - p));
            frac = 0;
            for (int i = 27; i >= 0; i--) begin
                x = (x * x) >> 31;
                if (x >= (64'd1 << 32)) begin
                    x = x >> 1;
                    frac = frac | (64'sd1 << i);
                end
            end
            lg2  = (longint'(p) - 16) * (64'sd1 <<< 28) + frac;
            ln_r = (lg2 * longint'(LN2_Q30)) >>> 34;
            sq   = (ln_r * ln_r) >>> 24;
            cube = (sq * ln_r) >>> 32;
            den  = longint'(sh_a) + ((longint'(sh_b) * ln_r) >>> 24)
                 + ((longint'(sh_c) * cube) >>> 16);
            if (den <= 0) kel = 64'sd1 <<< 32;
            else kel = longint'((64'd1 << 56) / 64'(den));
            if (kel > (64'sd1 <<< 32)) kel = 64'sd1 <<< 32;
            num = 180 * kel - 64'sd45967 * 64'sd65536;
            tc  = num / 65536;      // truncates toward zero
            if (tc > 131071) tc = 131071;
            if (tc < -131072) tc = -131072;
            r.temp = tc[TEMP_W-1:0];
        end
        return r;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        error_count++;
    endtask

    // sender: bursts with random gaps
    bit in_taken = 1'b0;
    int burst_left = 0;
    int gap_left = 0;
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (i_valid && !in_taken) begin
            // hold until the transfer
        end else if (gap_left > 0) begin
            gap_left <= gap_left - 1;
            i_valid <= 1'b0;
        end else if (pending_samples.size() > 0) begin
            t_sample s;
            s = pending_samples.pop_front();
            i_channel  <= s.channel;
            i_adc_code <= s.code;
            i_valid    <= 1'b1;
            if (burst_left <= 1) begin
                burst_left <= $urandom_range(1, 40);
                gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
            end else begin
                burst_left <= burst_left - 1;
            end
        end else begin
            i_valid <= 1'b0;
        end
    end

    // receiver: stall pattern is picked anew whenever ready_cnt wraps
    int ready_mode = 0;
    int ready_cnt = 0;
    always @(negedge i_clk) begin
        if (ready_cnt == 63) ready_mode <= $urandom_range(0, 3);
        ready_cnt <= (ready_cnt + 1) % 64;
        case (ready_mode)
            0: begin
                i_ready <= 1'b1;
            end
            1: begin
                i_ready <= ($urandom_range(0, 1) == 1);
            end
            2: begin
                i_ready <= ($urandom_range(0, 9) != 0);
            end
            default: begin
                i_ready <= ($urandom_range(0, 4) == 0);
            end
        endcase
    end

    // monitor and watchdog
    int idle_cycles = 0;
    always @(posedge i_clk) begin
        in_taken <= i_valid && o_ready;
        if (i_rst_n) begin
            if (i_valid && o_ready)
                expected_readings.push_back(convert_sample('{i_channel, i_adc_code}));
            if (o_valid && i_ready) begin
                if (expected_readings.size() == 0) begin
                    report_mismatch("unexpected result, channel", o_channel_out, -1);
                end else begin
                    t_reading w;
                    w = expected_readings.pop_front();
                    if (o_channel_out !== w.channel)
                        report_mismatch("channel_out", o_channel_out, w.channel);
                    if (o_temp_centi_f !== w.temp)
                        report_mismatch("temp_centi_f", o_temp_centi_f, w.temp);
                    if (o_status !== w.status)
                        report_mismatch("status", o_status, w.status);
                end
            end
            if ((i_valid && o_ready) || (o_valid && i_ready)
                    || (pending_samples.size() == 0 && expected_readings.size() == 0
                        && !i_valid))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WD_LIMIT) begin
                $display("thermistor_steinhart_hart test failed");
                $finish;
            end
        end
    end

    task automatic write_reg(logic [IDX_W-1:0] idx, logic [DATA_W-1:0] value);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= value;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            REG_SERIES: series_ohms = value[SR_W-1:0];
            REG_COEF_A: sh_a = value;
            REG_COEF_B: sh_b = value;
            REG_COEF_C: sh_c = value;
            default: ;
        endcase
    endtask

    task automatic set_regs(logic [DATA_W-1:0] sr, logic [DATA_W-1:0] a,
                            logic [DATA_W-1:0] b, logic [DATA_W-1:0] c);
        write_reg(REG_SERIES, sr);
        write_reg(REG_COEF_A, a);
        write_reg(REG_COEF_B, b);
        write_reg(REG_COEF_C, c);
    endtask

    task automatic drain();
        wait (pending_samples.size() == 0 && !i_valid && expected_readings.size() == 0);
        repeat (150) @(negedge i_clk);
    endtask

    task automatic add_random(int count);
        t_sample s;
        int pick;
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(0, 19);
            s.channel = CH_W'($urandom_range(0, 15));
            if (pick == 0) s.code = '0;
            else if (pick == 1) s.code = ADC_BITS'(FULL);
            else if (pick == 2) s.code = ADC_BITS'($urandom_range(1, 8));
            else if (pick == 3) s.code = ADC_BITS'(FULL - longint'($urandom_range(1, 8)));
            else s.code = ADC_BITS'($urandom_range(0, 1023));
            pending_samples.push_back(s);
        end
    endtask

    initial begin
        logic [ADC_BITS-1:0] edge_codes[10];
        edge_codes = '{0, 1, 2, 3, 341, 511, 512, 682, 1022, 1023};
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // open, short and neighbors at reset defaults, every channel
        for (int k = 0; k < 16; k++)
            pending_samples.push_back('{4'(k), edge_codes[k % 10]});
        for (int k = 0; k < 4; k++)
            pending_samples.push_back('{4'hF >> k, 10'h3FF >> k});
        add_random(250);
        drain();

        // smallest and zero divider resistor, zero coefficients
        set_regs(1, 0, 0, 0);
        for (int k = 0; k < 10; k++) pending_samples.push_back('{4'(k), edge_codes[k]});
        add_random(120);
        drain();
        write_reg(REG_SERIES, 0);
        add_random(120);
        drain();

        // large divider resistor with all-ones coefficients, then the largest with only B all ones
        set_regs(1000000, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        for (int k = 0; k < 10; k++) pending_samples.push_back('{4'(k), edge_codes[k]});
        add_random(150);
        drain();
        set_regs(20'hFFFFF, 0, 32'hFFFF_FFFF, 0);
        add_random(150);
        drain();

        // tiny denominator drives kelvin to its ceiling
        set_regs(100, 1, 0, 1);
        add_random(150);
        drain();

        // random settings
        for (int ph = 0; ph < 3; ph++) begin
            set_regs($urandom_range(1, 1000000), $urandom, $urandom >> $urandom_range(0, 16),
                     $urandom >> $urandom_range(0, 24));
            add_random(100);
            drain();
        end

        set_regs(RST_SERIES, RST_COEF_A, RST_COEF_B, RST_COEF_C);
        add_random(100);
        drain();

        if (error_count == 0) begin
            $display("thermistor_steinhart_hart test passed");
        end else begin
            $display("thermistor_steinhart_hart test failed");
        end
        $finish;
    end
endmodule

@@ files.f @@
rtl/core/tsh_pkg.sv
rtl/core/tsh_front.sv
rtl/core/tsh_queue.sv
rtl/core/tsh_div.sv
rtl/core/tsh_log.sv
rtl/core/tsh_back.sv
rtl/core/thermistor_steinhart_hart.sv
test/tb_thermistor_steinhart_hart.sv
